@@ rtl/sirc_pkg.sv @@
// Shared types, constants and saturation helpers for the stereo IR convolver.
package sirc_pkg;

    localparam int PARTITION_SIZE = 128;
    localparam int MAX_PARTITIONS = 16;
    localparam int TAPS           = PARTITION_SIZE * MAX_PARTITIONS;
    localparam int TAPS_W         = $clog2(TAPS);
    localparam int ACC_W          = 32 + TAPS_W + 1;
    localparam int ACC_LO_W       = ACC_W / 2;
    localparam int ACC_HI_W       = ACC_W - ACC_LO_W;
    localparam int FULL_W         = ACC_W + 17;
    localparam int SCALE_SHIFT    = 27;
    localparam int FILT_SHIFT     = 16;

    localparam logic [2:0] CFG_PARTITIONS = 3'd0;
    localparam logic [2:0] CFG_GAIN       = 3'd1;
    localparam logic [2:0] CFG_LP_ALPHA   = 3'd2;
    localparam logic [2:0] CFG_HP_ALPHA   = 3'd3;
    localparam logic [2:0] CFG_FILT_EN    = 3'd4;
    localparam logic [2:0] CFG_BYPASS     = 3'd5;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef struct packed {
        logic               action;
        logic [10:0]        coefficient_index;
        logic signed [15:0] coefficient_value;
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic               left_present;
        logic               right_present;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic               left_valid;
        logic               right_valid;
    } t_out_item;

    typedef enum logic [2:0] {
        FS_MUL_LO = 3'd0,
        FS_MUL_HI = 3'd1,
        FS_SCALE  = 3'd2,
        FS_LP_MUL = 3'd3,
        FS_LP_ADD = 3'd4,
        FS_HP_MUL = 3'd5,
        FS_HP_ADD = 3'd6
    } t_fin_step;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic              hist_we;
        logic              hist_zero;
        logic [TAPS_W-1:0] hist_waddr;
        logic              rd_en;
        logic [TAPS_W-1:0] rd_addr;
        logic              acc_clr;
        logic              fin_en;
        t_fin_step         fin_step;
        logic              state_clr;
    } t_lane_ctrl;

    typedef struct packed {
        logic [15:0] gain;
        logic [15:0] lp_alpha;
        logic [15:0] hp_alpha;
        logic        filt_en;
    } t_tone_cfg;

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        if (v > 64'sd8388607) begin
            return 24'sd8388607;
        end else if (v < -64'sd8388608) begin
            return -24'sd8388608;
        end
        return v[23:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
        if (v > 24'sd32767) begin
            return 16'sd32767;
        end else if (v < -24'sd32768) begin
            return -16'sd32768;
        end
        return v[15:0];
    endfunction

endpackage

@@ rtl/sirc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sirc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/sirc_lane.sv @@
// One channel lane: delay line, multiply-accumulate, gain and tone filters.
module sirc_lane
    import sirc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_lane_ctrl         i_ctrl,
    input  t_tone_cfg          i_cfg,
    input  logic signed [15:0] i_sample,
    input  logic               i_present,
    input  logic signed [15:0] i_coef,
    output logic signed [15:0] o_result
);

    logic [15:0]                r_hdata_u;
    logic signed [15:0]         hdata;
    logic                       r_present;
    logic                       r_v1;
    logic                       r_v2;
    logic signed [31:0]         r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic [ACC_LO_W+15:0]       r_plo;
    logic signed [ACC_HI_W+16:0] r_phi;
    logic signed [23:0]         r_v;
    logic signed [23:0]         r_y;
    logic signed [42:0]         r_m;
    logic signed [23:0]         r_lp;
    logic signed [23:0]         r_hpo;
    logic signed [23:0]         r_hpi;
    logic signed [15:0]         r_res;

    logic signed [FULL_W-1:0]   full;
    logic signed [FULL_W-1:0]   scaled;
    logic signed [23:0]         scale_v;
    logic signed [24:0]         lp_diff;
    logic signed [23:0]         lp_y;
    logic signed [25:0]         hp_sum;
    logic signed [23:0]         hp_v;
    logic                       upd;

    sirc_ram #(.WIDTH(16), .DEPTH(TAPS)) u_hist (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.hist_we),
        .i_waddr (i_ctrl.hist_waddr),
        .i_wdata (i_ctrl.hist_zero ? 16'd0 : i_sample),
        .i_raddr (i_ctrl.rd_addr),
        .o_rdata (r_hdata_u)
    );

    assign hdata = $signed(r_hdata_u);
    assign upd   = i_cfg.filt_en && r_present;

    always_comb begin
        full    = (FULL_W'(r_phi) <<< ACC_LO_W) + FULL_W'($signed({1'b0, r_plo}));
        scaled  = (full + (FULL_W'(1) <<< (SCALE_SHIFT - 1))) >>> SCALE_SHIFT;
        scale_v = sat24(64'(scaled));
        lp_diff = 25'(r_v) - 25'(r_lp);
        lp_y    = sat24(64'(r_lp) + 64'((r_m + 43'sd32768) >>> FILT_SHIFT));
        hp_sum  = 26'(r_hpo) + 26'(r_y) - 26'(r_hpi);
        hp_v    = sat24(64'((r_m + 43'sd32768) >>> FILT_SHIFT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_present <= 1'b0;
            r_lp      <= '0;
            r_hpo     <= '0;
            r_hpi     <= '0;
        end else begin
            r_v1 <= i_ctrl.rd_en;
            r_v2 <= r_v1;
            if (i_ctrl.start) begin
                r_present <= i_present;
            end
            if (i_ctrl.state_clr) begin
                r_lp  <= '0;
                r_hpo <= '0;
                r_hpi <= '0;
            end else if (i_ctrl.fin_en && upd) begin
                if (i_ctrl.fin_step == FS_LP_ADD) begin
                    r_lp <= lp_y;
                end
                if (i_ctrl.fin_step == FS_HP_ADD) begin
                    r_hpo <= hp_v;
                    r_hpi <= r_y;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= i_coef * hdata;
        end
        if (i_ctrl.acc_clr) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_ctrl.fin_en) begin
            unique case (i_ctrl.fin_step)
                FS_MUL_LO: r_plo <= r_acc[ACC_LO_W-1:0] * i_cfg.gain;
                FS_MUL_HI: r_phi <= $signed(r_acc[ACC_W-1:ACC_LO_W]) * $signed({1'b0, i_cfg.gain});
                FS_SCALE: begin
                    r_v   <= scale_v;
                    r_res <= sat16(scale_v);
                end
                FS_LP_MUL: r_m <= 43'($signed({1'b0, i_cfg.lp_alpha}) * lp_diff);
                FS_LP_ADD: r_y <= lp_y;
                FS_HP_MUL: r_m <= $signed({1'b0, i_cfg.hp_alpha}) * hp_sum;
                FS_HP_ADD: begin
                    if (i_cfg.filt_en) begin
                        r_res <= sat16(hp_v);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_result = r_res;

endmodule

@@ rtl/stereo_ir_convolver_with_tone_filters_core.sv @@
// Top level: shared coefficient store, two channel lanes, sequencer and output register.
//
//  channel  handshake                 payload
//  input    i_in_valid / o_in_ready   i_in  (t_in_item)
//  output   o_out_valid / i_out_ready o_out (t_out_item)
//  config   i_cfg_we                  i_cfg_index, i_cfg_data
//
//  Audio transaction: states IDLE, MAC over N*128 taps, DRAIN, FIN and OUT, with
//  N = partition count (1..16); the tap loop over the history and coefficient RAM
//  read ports sets its length. Bypass transaction: IDLE then OUT. Coefficient load: tap 0 adds a clear.
//  After reset and after loading tap 0 the delay lines are cleared with o_in_ready low.
//  A waiting result does not block the next transaction until that one finishes.
module stereo_ir_convolver_with_tone_filters_core
    import sirc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    t_state            r_state, n_state;
    logic [TAPS_W-1:0] r_cnt, n_cnt;
    logic [TAPS_W-1:0] r_ptr, n_ptr;
    logic [TAPS_W-1:0] r_pos, n_pos;
    logic [TAPS_W-1:0] r_last, n_last;
    t_fin_step         r_step, n_step;
    logic              r_bypass_item, n_bypass_item;
    t_in_item          r_item, n_item;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out, n_out;

    logic [4:0]        r_pc;
    logic [15:0]       r_gain;
    logic [15:0]       r_lp_alpha;
    logic [15:0]       r_hp_alpha;
    logic              r_filt_en;
    logic              r_bypass;

    t_lane_ctrl        ctrl;
    t_tone_cfg         tcfg;
    logic              accept;
    logic              coef_we;
    logic [15:0]       coef_u;
    logic signed [15:0] left_res;
    logic signed [15:0] right_res;
    logic [4:0]        pc_eff;
    logic [TAPS_W:0]   tap_len;

    assign accept = i_in_valid && o_in_ready;
    assign coef_we = accept && (i_in.action == ACT_LOAD)
                     && (32'(i_in.coefficient_index) < 32'(TAPS));

    assign tcfg = '{gain: r_gain, lp_alpha: r_lp_alpha, hp_alpha: r_hp_alpha,
                    filt_en: r_filt_en};

    always_comb begin
        if (r_pc == 5'd0) begin
            pc_eff = 5'd1;
        end else if (32'(r_pc) > 32'(MAX_PARTITIONS)) begin
            pc_eff = 5'(MAX_PARTITIONS);
        end else begin
            pc_eff = r_pc;
        end
        tap_len = (TAPS_W + 1)'(pc_eff) * (TAPS_W + 1)'(PARTITION_SIZE);
    end

    sirc_ram #(.WIDTH(16), .DEPTH(TAPS)) u_coef (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (i_in.coefficient_index[TAPS_W-1:0]),
        .i_wdata (i_in.coefficient_value),
        .i_raddr (r_cnt),
        .o_rdata (coef_u)
    );

    sirc_lane u_left (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_cfg     (tcfg),
        .i_sample  (i_in.left_present ? i_in.left_sample : 16'sd0),
        .i_present (i_in.left_present),
        .i_coef    ($signed(coef_u)),
        .o_result  (left_res)
    );

    sirc_lane u_right (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_cfg     (tcfg),
        .i_sample  (i_in.right_present ? i_in.right_sample : 16'sd0),
        .i_present (i_in.right_present),
        .i_coef    ($signed(coef_u)),
        .o_result  (right_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= 5'd16;
            r_gain     <= 16'd4096;
            r_lp_alpha <= 16'd45548;
            r_hp_alpha <= 16'd65350;
            r_filt_en  <= 1'b0;
            r_bypass   <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PARTITIONS: r_pc       <= i_cfg_data[4:0];
                CFG_GAIN:       r_gain     <= i_cfg_data;
                CFG_LP_ALPHA:   r_lp_alpha <= i_cfg_data;
                CFG_HP_ALPHA:   r_hp_alpha <= i_cfg_data;
                CFG_FILT_EN:    r_filt_en  <= i_cfg_data[0];
                CFG_BYPASS:     r_bypass   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_cnt       <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos         <= n_pos;
        r_last        <= n_last;
        r_step        <= n_step;
        r_bypass_item <= n_bypass_item;
        r_item        <= n_item;
        r_out         <= n_out;
    end

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_ptr         = r_ptr;
        n_pos         = r_pos;
        n_last        = r_last;
        n_step        = r_step;
        n_bypass_item = r_bypass_item;
        n_item        = r_item;
        n_out_valid   = r_out_valid;
        n_out         = r_out;
        o_in_ready    = 1'b0;
        ctrl          = '{fin_step: FS_MUL_LO, default: '0};

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_CLEAR: begin
                ctrl.hist_we    = 1'b1;
                ctrl.hist_zero  = 1'b1;
                ctrl.hist_waddr = r_cnt;
                if (32'(r_cnt) == TAPS - 1) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    n_item = i_in;
                    if (i_in.action == ACT_LOAD) begin
                        if (i_in.coefficient_index == '0) begin
                            ctrl.state_clr = 1'b1;
                            n_ptr   = '0;
                            n_cnt   = '0;
                            n_state = ST_CLEAR;
                        end
                    end else if (i_in.left_present || i_in.right_present) begin
                        if (r_bypass) begin
                            n_bypass_item = 1'b1;
                            n_state       = ST_OUT;
                        end else begin
                            n_bypass_item   = 1'b0;
                            ctrl.start      = 1'b1;
                            ctrl.acc_clr    = 1'b1;
                            ctrl.hist_we    = 1'b1;
                            ctrl.hist_waddr = r_ptr;
                            n_pos   = r_ptr;
                            n_last  = TAPS_W'(tap_len - 1'b1);
                            n_cnt   = '0;
                            n_state = ST_MAC;
                        end
                    end
                end
            end
            ST_MAC: begin
                ctrl.rd_en   = 1'b1;
                ctrl.rd_addr = r_pos;
                n_pos = (r_pos == '0) ? TAPS_W'(TAPS - 1) : r_pos - 1'b1;
                if (r_cnt == r_last) begin
                    n_cnt   = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (r_cnt[0]) begin
                    n_cnt   = '0;
                    n_step  = FS_MUL_LO;
                    n_state = ST_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FIN: begin
                ctrl.fin_en   = 1'b1;
                ctrl.fin_step = r_step;
                if (r_step == FS_HP_ADD) begin
                    n_ptr   = (32'(r_ptr) == TAPS - 1) ? '0 : r_ptr + 1'b1;
                    n_state = ST_OUT;
                end else begin
                    n_step = t_fin_step'(r_step + 3'd1);
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid       = 1'b1;
                    n_out.left_valid  = r_item.left_present;
                    n_out.right_valid = r_item.right_present;
                    if (r_bypass_item) begin
                        n_out.left_out  = r_item.left_present ? r_item.left_sample : 16'sd0;
                        n_out.right_out = r_item.right_present ? r_item.right_sample : 16'sd0;
                    end else begin
                        n_out.left_out  = r_item.left_present ? left_res : 16'sd0;
                        n_out.right_out = r_item.right_present ? right_res : 16'sd0;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
